// File: rtl/core/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants of the serial link frame receiver: size codes,
// frame lengths, status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package slfr_pkg;

	// size byte codes
	localparam logic [7:0] SIZE_ACK     = 8'h7F;
	localparam logic [7:0] SIZE_REG_ACK = 8'h7E;

	// frame lengths
	localparam logic [8:0] LEN_ACK     = 9'd5;
	localparam logic [8:0] LEN_REG_ACK = 9'd8;
	localparam logic [8:0] LEN_EXTRA   = 9'd6;
	localparam logic [8:0] LEN_DEFAULT = 9'd5;

	// frame status codes
	localparam logic [2:0] ST_PROGRESS   = 3'd0;
	localparam logic [2:0] ST_ACK        = 3'd1;
	localparam logic [2:0] ST_REG_ACK    = 3'd2;
	localparam logic [2:0] ST_DATA       = 3'd3;
	localparam logic [2:0] ST_BAD_SUM    = 3'd4;
	localparam logic [2:0] ST_WRONG_ADDR = 3'd5;

	// configuration register indexes
	localparam logic [0:0] REG_HOST_ID = 1'b0;
	localparam logic [0:0] REG_ALT_ID  = 1'b1;

	// register reset values
	localparam logic [7:0] HOST_ID_RST = 8'h78;
	localparam logic [7:0] ALT_ID_RST  = 8'hF8;

	// one result item
	typedef struct packed {
		logic [7:0] data_byte;
		logic [8:0] position;
		logic       last;
		logic [2:0] status;
		logic [7:0] ack_dest;
		logic [7:0] ack_seq;
		logic [7:0] tx_seq;
		logic       link_up;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/slfr_in_stage.sv
// ----------------------------------------------------------------------------
// slfr_in_stage
// Input register: holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	logic load;

	// free slot, or the held byte leaves this cycle
	assign in_ready = !valid_s1 || advance;
	assign load     = in_valid && in_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/slfr_frame_core.sv
// ----------------------------------------------------------------------------
// slfr_frame_core
// Frame state and decode: configuration registers, byte position, length,
// running checksum, header capture, transmit sequence and link flag.
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_frame_core
	import slfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       step,
	input  wire logic [7:0] byte_s1,
	output logic            res_keep,
	output result_t         res
);

	logic [7:0] host_id_q;
	logic [7:0] alt_id_q;
	logic [8:0] byte_index_q;
	logic [8:0] frame_length_q;
	logic [7:0] running_xor_q;
	logic [7:0] source_byte_q;
	logic [7:0] second_byte_q;
	logic [7:0] size_byte_q;
	logic [7:0] previous_byte_q;
	logic [7:0] tx_seq_q;
	logic       link_q;

	logic       drop;
	logic [8:0] len_next;
	logic [8:0] idx_inc;
	logic       is_last;
	logic       addr_ok;
	logic       is_ctrl;
	logic [2:0] status;
	logic [7:0] tx_seq_next;
	logic       link_next;
	logic       update;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_id_q <= HOST_ID_RST;
			alt_id_q  <= ALT_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOST_ID: host_id_q <= cfg_data;
				REG_ALT_ID:  alt_id_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// between frames only an address byte or zero opens a frame
	assign drop = (byte_index_q == 9'd0) && (byte_s1 != host_id_q)
		&& (byte_s1 != alt_id_q) && (byte_s1 != 8'h00);

	// length from the size byte, taken at the third position
	always_comb begin
		len_next = frame_length_q;
		if (byte_index_q == 9'd2) begin
			if (byte_s1 == SIZE_ACK) begin
				len_next = LEN_ACK;
			end else if (byte_s1 == SIZE_REG_ACK) begin
				len_next = LEN_REG_ACK;
			end else begin
				len_next = {1'b0, byte_s1} + LEN_EXTRA;
			end
		end
	end

	assign idx_inc = byte_index_q + 9'd1;
	assign is_last = (idx_inc >= len_next);

	// header is complete before any final byte can arrive
	assign addr_ok = ((source_byte_q == host_id_q) || (source_byte_q == alt_id_q))
		&& (second_byte_q == 8'h00);
	assign is_ctrl = (size_byte_q == SIZE_ACK) || (size_byte_q == SIZE_REG_ACK);

	// final byte status
	always_comb begin
		status      = ST_PROGRESS;
		tx_seq_next = tx_seq_q;
		link_next   = link_q;
		if (is_last) begin
			if (!addr_ok) begin
				status = ST_WRONG_ADDR;
			end else if (byte_s1 != running_xor_q) begin
				status = ST_BAD_SUM;
			end else if (is_ctrl) begin
				tx_seq_next = tx_seq_q + 8'd1;
				if (size_byte_q == SIZE_ACK) begin
					status = ST_ACK;
				end else begin
					status    = ST_REG_ACK;
					link_next = 1'b1;
				end
			end else begin
				status = ST_DATA;
			end
		end
	end

	assign update   = step && !drop;
	assign res_keep = !drop;

	// result record
	always_comb begin
		res.data_byte = byte_s1;
		res.position  = byte_index_q;
		res.last      = is_last;
		res.status    = status;
		res.ack_dest  = (status == ST_DATA) ? source_byte_q : 8'h00;
		res.ack_seq   = (status == ST_DATA) ? previous_byte_q : 8'h00;
		res.tx_seq    = tx_seq_next;
		res.link_up   = link_next;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= 9'd0;
			frame_length_q  <= LEN_DEFAULT;
			running_xor_q   <= 8'h00;
			source_byte_q   <= 8'h00;
			second_byte_q   <= 8'h00;
			size_byte_q     <= 8'h00;
			previous_byte_q <= 8'h00;
			tx_seq_q        <= 8'h01;
			link_q          <= 1'b0;
		end else if (update) begin
			if (byte_index_q == 9'd0) begin
				source_byte_q <= byte_s1;
			end
			if (byte_index_q == 9'd1) begin
				second_byte_q <= byte_s1;
			end
			if (byte_index_q == 9'd2) begin
				size_byte_q <= byte_s1;
			end
			previous_byte_q <= byte_s1;
			tx_seq_q        <= tx_seq_next;
			link_q          <= link_next;
			if (is_last) begin
				byte_index_q   <= 9'd0;
				frame_length_q <= LEN_DEFAULT;
				running_xor_q  <= 8'h00;
			end else begin
				byte_index_q   <= idx_inc;
				frame_length_q <= len_next;
				running_xor_q  <= running_xor_q ^ byte_s1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/slfr_out_stage.sv
// ----------------------------------------------------------------------------
// slfr_out_stage
// Output register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_out_stage
	import slfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  result_t   res,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      room,
	output result_t   res_q
);

	// empty, or the held result leaves this cycle
	assign room = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// result payload, cleared so the fields start defined
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/serial_link_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_link_frame_receiver
// Splits serial-link bytes into frames and reports frame status.
// ----------------------------------------------------------------------------
// Each received byte goes through an input register, is decoded against the
// frame state combinationally and lands in an output register, so the block
// takes one byte per clock cycle while the output is not stalled. A byte
// outside a frame that is not host_id, alternate_id or zero is dropped and
// gives no result; every other byte gives one result with its position,
// and the final byte of a frame carries the status, the acknowledge fields
// and the updated transmit sequence and link flag.
// Registers: index 0 host_id (reset 0x78), index 1 alternate_id (reset 0xF8).
`default_nettype none

module serial_link_frame_receiver
	import slfr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      data_byte,
	output logic [8:0]      position,
	output logic            last,
	output logic [2:0]      status,
	output logic [7:0]      ack_dest,
	output logic [7:0]      ack_seq,
	output logic [7:0]      tx_seq,
	output logic            link_up
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       room;
	logic       res_keep;
	result_t    res;
	result_t    res_q;

	// byte leaves the input register when the output side has room
	assign advance = valid_s1 && room;

	slfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	slfr_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (advance),
		.byte_s1   (byte_s1),
		.res_keep  (res_keep),
		.res       (res)
	);

	slfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_keep),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.room      (room),
		.res_q     (res_q)
	);

	// result fields
	assign data_byte = res_q.data_byte;
	assign position  = res_q.position;
	assign last      = res_q.last;
	assign status    = res_q.status;
	assign ack_dest  = res_q.ack_dest;
	assign ack_seq   = res_q.ack_seq;
	assign tx_seq    = res_q.tx_seq;
	assign link_up   = res_q.link_up;

endmodule

`default_nettype wire

// File: rtl/core/slfr_checker.sv
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_checker
	import slfr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] data_byte,
	input wire logic [8:0] position,
	input wire logic       last,
	input wire logic [2:0] status,
	input wire logic [7:0] ack_dest,
	input wire logic [7:0] ack_seq,
	input wire logic       link_up
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte)
			&& $stable(position) && $stable(status))
		else $error("result changed while stalled");

	// status is reported on the final byte only
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (status != ST_PROGRESS)))
		else $error("status and last disagree");

	// acknowledge fields only for good data
	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_DATA) |-> (ack_dest == 8'h00) && (ack_seq == 8'h00))
		else $error("acknowledge fields set without good data");

	// a short acknowledge frame ends at its fifth byte
	a_ack_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_ACK) |-> (position == 9'd4))
		else $error("acknowledge frame of wrong length");

	// link once up stays up
	a_link_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(link_up))
		else $error("link flag dropped");

endmodule

bind serial_link_frame_receiver slfr_checker u_slfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_byte (data_byte),
	.position  (position),
	.last      (last),
	.status    (status),
	.ack_dest  (ack_dest),
	.ack_seq   (ack_seq),
	.link_up   (link_up)
);

`default_nettype wire

// File: tb/sv/serial_link_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// serial_link_frame_receiver_test
// Self-checking bench for the serial link frame receiver. Bytes are sent as
// whole frames (acknowledge, registration acknowledge, data) with random
// content, mixed with noise, stray zero bytes, broken addressing and bad
// checksums, under several host and alternate id settings. A scoreboard
// tracks the frame state and compares every output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_link_frame_receiver_test;

	import slfr_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 8;

	// frame tracker with the queue of awaited output bytes
	class link_frame_scoreboard;
		logic [7:0] host_id;
		logic [7:0] alt_id;
		logic [8:0] byte_idx;
		logic [8:0] frame_len;
		logic [7:0] xor_sum;
		logic [7:0] src_byte;
		logic [7:0] second_byte;
		logic [7:0] size_code;
		logic [7:0] prev_byte;
		logic [7:0] seq_count;
		logic       link_flag;
		bit         seq_wrapped;
		int         mismatch_count;
		result_t    awaited_bytes[$];

		function new();
			host_id = HOST_ID_RST;
			alt_id = ALT_ID_RST;
			byte_idx = '0;
			frame_len = LEN_DEFAULT;
			xor_sum = '0;
			src_byte = '0;
			second_byte = '0;
			size_code = '0;
			prev_byte = '0;
			seq_count = 8'd1;
			link_flag = 1'b0;
			seq_wrapped = 0;
			mismatch_count = 0;
		endfunction

		function void set_reg(input logic [0:0] idx, input logic [7:0] value);
			if (idx == REG_HOST_ID) host_id = value;
			else if (idx == REG_ALT_ID) alt_id = value;
		endfunction

		function int pending();
			return awaited_bytes.size();
		endfunction

		// advance the frame state by one accepted byte; 1 if it gives a result
		function bit take_rx_byte(input logic [7:0] b);
			result_t    r;
			logic [8:0] pos;
			pos = byte_idx;
			// dropped between frames
			if (pos == 0 && b != host_id && b != alt_id && b != 8'h00)
				return 0;
			// header fields
			if (pos == 9'd0) begin
				src_byte = b;
			end else if (pos == 9'd1) begin
				second_byte = b;
			end else if (pos == 9'd2) begin
				size_code = b;
				if (b == SIZE_ACK) frame_len = LEN_ACK;
				else if (b == SIZE_REG_ACK) frame_len = LEN_REG_ACK;
				else frame_len = {1'b0, b} + LEN_EXTRA;
			end
			byte_idx = pos + 9'd1;
			r = '0;
			r.data_byte = b;
			r.position = pos;
			r.status = ST_PROGRESS;
			// final byte decides the frame status
			if (byte_idx >= frame_len) begin
				r.last = 1'b1;
				if (!((src_byte == host_id || src_byte == alt_id) && second_byte == 8'h00)) begin
					r.status = ST_WRONG_ADDR;
				end else if (b != xor_sum) begin
					r.status = ST_BAD_SUM;
				end else if (size_code == SIZE_ACK || size_code == SIZE_REG_ACK) begin
					if (size_code == SIZE_ACK) begin
						r.status = ST_ACK;
					end else begin
						r.status = ST_REG_ACK;
						link_flag = 1'b1;
					end
					if (seq_count == 8'hFF) seq_wrapped = 1;
					seq_count = seq_count + 8'd1;
				end else begin
					r.status = ST_DATA;
					r.ack_dest = src_byte;
					r.ack_seq = prev_byte;
				end
				byte_idx = '0;
				frame_len = LEN_DEFAULT;
				xor_sum = '0;
			end else begin
				xor_sum = xor_sum ^ b;
			end
			prev_byte = b;
			r.tx_seq = seq_count;
			r.link_up = link_flag;
			awaited_bytes.push_back(r);
			return 1;
		endfunction

		function void report(input string field, input logic [8:0] want, input logic [8:0] got);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		endfunction

		// compare one output transfer with the oldest awaited byte
		function void check_out_byte(input result_t got);
			result_t want;
			if (awaited_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected output byte %h at position %0d, none awaited",
						got.data_byte, got.position);
				return;
			end
			want = awaited_bytes.pop_front();
			if (got.data_byte !== want.data_byte) report("data_byte", want.data_byte, got.data_byte);
			if (got.position !== want.position) report("position", want.position, got.position);
			if (got.last !== want.last) report("last", want.last, got.last);
			if (got.status !== want.status) report("status", want.status, got.status);
			if (got.ack_dest !== want.ack_dest) report("ack_dest", want.ack_dest, got.ack_dest);
			if (got.ack_seq !== want.ack_seq) report("ack_seq", want.ack_seq, got.ack_seq);
			if (got.tx_seq !== want.tx_seq) report("tx_seq", want.tx_seq, got.tx_seq);
			if (got.link_up !== want.link_up) report("link_up", want.link_up, got.link_up);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic [8:0] position;
	logic       last;
	logic [2:0] status;
	logic [7:0] ack_dest;
	logic [7:0] ack_seq;
	logic [7:0] tx_seq;
	logic       link_up;

	link_frame_scoreboard board;
	bit         calm;
	int         stall_left = 0;
	int         quiet_cycles = 0;
	int         result_items = 0;
	logic [7:0] cur_host;
	logic [7:0] cur_alt;

	serial_link_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_byte (data_byte),
		.position  (position),
		.last      (last),
		.status    (status),
		.ack_dest  (ack_dest),
		.ack_seq   (ack_seq),
		.tx_seq    (tx_seq),
		.link_up   (link_up)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver side with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_out_byte(result_t'({data_byte, position, last, status,
				ack_dest, ack_seq, tx_seq, link_up}));
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// one byte transfer, with an optional gap before it
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (board.take_rx_byte(b)) result_items++;
	endtask

	// hold the sender until every awaited byte has come out
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// one frame: header, random body, checksum right or corrupted
	task automatic send_frame(input logic [7:0] src, input logic [7:0] second,
		input logic [7:0] size_code, input bit good_sum);
		logic [7:0] sum;
		logic [7:0] b;
		int         len;
		if (size_code == SIZE_ACK) len = LEN_ACK;
		else if (size_code == SIZE_REG_ACK) len = LEN_REG_ACK;
		else len = int'(size_code) + int'(LEN_EXTRA);
		sum = src ^ second ^ size_code;
		send_byte(src);
		send_byte(second);
		send_byte(size_code);
		for (int k = 3; k < len - 1; k++) begin
			b = 8'($urandom_range(0, 255));
			sum = sum ^ b;
			send_byte(b);
		end
		if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	// mostly well-formed frames, some noise and broken ones
	task automatic send_random_frame(input bit ack_heavy);
		logic [7:0] src;
		logic [7:0] second;
		logic [7:0] size_code;
		int         pick;
		// noise between frames
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 99);
		if (pick < 5) src = 8'h00;
		else if (pick < 52) src = cur_host;
		else src = cur_alt;
		second = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		pick = $urandom_range(0, 99);
		if (ack_heavy) begin
			if (pick < 80) size_code = SIZE_ACK;
			else if (pick < 95) size_code = SIZE_REG_ACK;
			else size_code = 8'($urandom_range(0, 8));
		end else begin
			if (pick < 35) size_code = SIZE_ACK;
			else if (pick < 50) size_code = SIZE_REG_ACK;
			else if (pick < 90) size_code = 8'($urandom_range(0, 10));
			else if (pick < 98) size_code = 8'($urandom_range(13, 60));
			else size_code = 8'($urandom_range(150, 255));
		end
		send_frame(src, second, size_code, $urandom_range(0, 9) != 0);
	endtask

	// register writes while the block is idle
	task automatic set_ids(input logic [7:0] host, input logic [7:0] alt);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_HOST_ID;
		cfg_data <= host;
		board.set_reg(REG_HOST_ID, host);
		@(posedge clk);
		cfg_index <= REG_ALT_ID;
		cfg_data <= alt;
		board.set_reg(REG_ALT_ID, alt);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_host = host;
		cur_alt = alt;
	endtask

	// random frames until count results, calm over the last calm_tail of them
	task automatic run_random(input int count, input int calm_tail);
		int start;
		start = result_items;
		while (result_items - start < count) begin
			if (result_items - start >= count - calm_tail) calm = 1;
			else if ($urandom_range(0, 7) == 0) calm = !calm;
			if (!calm && $urandom_range(0, 29) == 0) hold_until_drained();
			send_random_frame(0);
		end
	endtask

	initial begin
		logic [7:0] id;
		logic [7:0] src;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HOST_ID;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		calm = 0;
		cur_host = HOST_ID_RST;
		cur_alt = ALT_ID_RST;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames under the reset ids
		send_byte(8'h55);
		send_byte(8'hFF);
		send_frame(HOST_ID_RST, 8'h00, SIZE_ACK, 1);
		send_frame(ALT_ID_RST, 8'h00, SIZE_REG_ACK, 1);
		send_frame(HOST_ID_RST, 8'h00, 8'h00, 1);
		send_frame(HOST_ID_RST, 8'h00, SIZE_ACK, 0);
		// zero start byte, addressing and checksum both wrong
		send_frame(8'h00, 8'h00, SIZE_ACK, 0);

		// extreme ids, one longest frame first
		set_ids(8'hFF, 8'h00);
		send_frame(8'hFF, 8'h00, 8'hFF, 1);
		run_random(40, 0);
		set_ids(8'h00, 8'hFF);
		run_random(40, 0);

		// acknowledge traffic until the transmit sequence wraps
		set_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		while (!board.seq_wrapped) begin
			if ($urandom_range(0, 7) == 0) calm = !calm;
			if ($urandom_range(0, 7) == 0) begin
				send_random_frame(1);
			end else begin
				src = ($urandom_range(0, 1) == 0) ? cur_host : cur_alt;
				send_frame(src, 8'h00, SIZE_ACK, 1);
			end
		end

		// both ids equal, no idling at the end
		id = 8'($urandom_range(0, 255));
		set_ids(id, id);
		run_random(60, 30);

		hold_until_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (board.mismatch_count == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
